// ===== rtl/tlvp_pkg.sv =====
// Shared types and codes for the TLV unit stream parser.
package tlvp_pkg;

    // Byte roles reported with every result
    localparam logic [1:0] ROLE_TAG     = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_TAG_LONG    = 3'd1;
    localparam logic [2:0] ERR_TAG_CUT     = 3'd2;
    localparam logic [2:0] ERR_LEN_CUT     = 3'd3;
    localparam logic [2:0] ERR_LEN_NONCANON = 3'd4;
    localparam logic [2:0] ERR_PAY_CUT     = 3'd5;

    localparam int TAG_W = 29;
    localparam int LEN_W = 64;

    // CompactSize prefixes and minimum canonical values
    localparam logic [7:0]       LEN_PREFIX_FIRST = 8'd253;
    localparam logic [LEN_W-1:0] LEN_MIN_16       = 64'd253;
    localparam logic [LEN_W-1:0] LEN_MIN_32       = 64'h0000_0000_0001_0000;
    localparam logic [LEN_W-1:0] LEN_MIN_64       = 64'h0000_0001_0000_0000;

    // Prefix kinds as held after the prefix byte
    localparam logic [1:0] KIND_16 = 2'd1;
    localparam logic [1:0] KIND_32 = 2'd2;

    // Count of tag bytes already taken at which a continued byte is too many
    localparam logic [2:0] TAG_LAST_COUNT = 3'd3;

    typedef struct packed {
        logic [1:0]       role;
        logic [7:0]       payload;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] length;
        logic             done;
        logic [2:0]       err;
        logic             ok;
    } result_t;

endpackage

// ===== rtl/tlvp_in_stage.sv =====
// Input register stage of the TLV unit stream parser.
module tlvp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_data,
    output logic       held_last
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       take;

    // Stall only when a byte is held and cannot move on this cycle
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;
    assign held_last  = last_reg;
endmodule

// ===== rtl/tlvp_parse_core.sv =====
// Parse state and per-byte decode logic of the TLV unit stream parser.
module tlvp_parse_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output tlvp_pkg::result_t res
);
    import tlvp_pkg::*;

    localparam logic [2:0] PH_TAG = 3'd0;
    localparam logic [2:0] PH_LEN = 3'd1;
    localparam logic [2:0] PH_EXT = 3'd2;
    localparam logic [2:0] PH_PAY = 3'd3;
    localparam logic [2:0] PH_ERR = 3'd4;

    logic [2:0]       phase_reg,    phase_next;
    logic [TAG_W-1:0] tag_acc_reg,  tag_acc_next;
    logic [2:0]       tag_cnt_reg,  tag_cnt_next;
    logic [LEN_W-1:0] len_acc_reg,  len_acc_next;
    logic [3:0]       len_left_reg, len_left_next;
    logic [1:0]       len_kind_reg, len_kind_next;
    logic [LEN_W-1:0] pay_left_reg, pay_left_next;
    logic [2:0]       err_reg,      err_next;

    logic [TAG_W-1:0] tag_shift;
    logic [TAG_W-1:0] tag_inc;
    logic [3:0]       len_total;
    logic [3:0]       len_pos;
    logic [LEN_W-1:0] len_merged;
    logic [LEN_W-1:0] len_min;
    logic [2:0]       err;
    logic             done;
    logic             clear_unit;
    logic             restart;

    assign tag_shift = {tag_acc_reg[TAG_W-8:0], data_byte[6:0]};
    assign tag_inc   = tag_shift + {{(TAG_W-1){1'b0}}, 1'b1};

    assign len_total = (len_kind_reg == KIND_16) ? 4'd2 :
                       (len_kind_reg == KIND_32) ? 4'd4 : 4'd8;
    assign len_pos   = len_total - len_left_reg;
    // Little-endian: drop the byte into its lane
    assign len_merged = len_acc_reg |
                        ({{(LEN_W-8){1'b0}}, data_byte} << {len_pos[2:0], 3'b000});
    assign len_min   = (len_kind_reg == KIND_16) ? LEN_MIN_16 :
                       (len_kind_reg == KIND_32) ? LEN_MIN_32 : LEN_MIN_64;

    always_comb
    begin
        phase_next    = phase_reg;
        tag_acc_next  = tag_acc_reg;
        tag_cnt_next  = tag_cnt_reg;
        len_acc_next  = len_acc_reg;
        len_left_next = len_left_reg;
        len_kind_next = len_kind_reg;
        pay_left_next = pay_left_reg;
        err_next      = err_reg;
        res           = '0;
        err           = ERR_NONE;
        done          = 1'b0;
        clear_unit    = 1'b0;
        restart       = 1'b0;

        case (phase_reg)
            PH_TAG:
            begin
                res.role     = ROLE_TAG;
                tag_cnt_next = tag_cnt_reg + 3'd1;
                if (data_byte[7])
                begin
                    tag_acc_next = tag_inc;
                    if (tag_cnt_reg >= TAG_LAST_COUNT)
                    begin
                        err = ERR_TAG_LONG;
                    end
                    else if (last_byte)
                    begin
                        err = ERR_TAG_CUT;
                    end
                end
                else
                begin
                    tag_acc_next = tag_shift;
                    res.tag      = tag_shift;
                    phase_next   = PH_LEN;
                    if (last_byte)
                    begin
                        err = ERR_LEN_CUT;
                    end
                end
            end
            PH_LEN:
            begin
                res.role = ROLE_LENGTH;
                res.tag  = tag_acc_reg;
                if (data_byte < LEN_PREFIX_FIRST)
                begin
                    len_acc_next = {{(LEN_W-8){1'b0}}, data_byte};
                    res.length   = {{(LEN_W-8){1'b0}}, data_byte};
                    if (data_byte == 8'd0)
                    begin
                        done       = 1'b1;
                        clear_unit = 1'b1;
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        pay_left_next = {{(LEN_W-8){1'b0}}, data_byte};
                        phase_next    = PH_PAY;
                        if (last_byte)
                        begin
                            err = ERR_PAY_CUT;
                        end
                    end
                end
                else
                begin
                    // 253, 254, 255 map to kinds 1, 2, 3 by their low bits
                    len_kind_next = data_byte[1:0];
                    len_left_next = (data_byte[1:0] == KIND_16) ? 4'd2 :
                                    (data_byte[1:0] == KIND_32) ? 4'd4 : 4'd8;
                    len_acc_next  = '0;
                    phase_next    = PH_EXT;
                    if (last_byte)
                    begin
                        err = ERR_LEN_CUT;
                    end
                end
            end
            PH_EXT:
            begin
                res.role      = ROLE_LENGTH;
                res.tag       = tag_acc_reg;
                len_acc_next  = len_merged;
                len_left_next = len_left_reg - 4'd1;
                if (len_left_reg == 4'd1)
                begin
                    if (len_merged < len_min)
                    begin
                        err = ERR_LEN_NONCANON;
                    end
                    else
                    begin
                        res.length    = len_merged;
                        pay_left_next = len_merged;
                        phase_next    = PH_PAY;
                        if (last_byte)
                        begin
                            err = ERR_PAY_CUT;
                        end
                    end
                end
                else if (last_byte)
                begin
                    err = ERR_LEN_CUT;
                end
            end
            PH_PAY:
            begin
                res.role      = ROLE_PAYLOAD;
                res.payload   = data_byte;
                res.tag       = tag_acc_reg;
                res.length    = len_acc_reg;
                pay_left_next = pay_left_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                if (pay_left_reg == {{(LEN_W-1){1'b0}}, 1'b1})
                begin
                    done       = 1'b1;
                    clear_unit = 1'b1;
                    phase_next = PH_TAG;
                end
                else if (last_byte)
                begin
                    err = ERR_PAY_CUT;
                end
            end
            default:
            begin
                res.role = ROLE_IGNORED;
                err      = err_reg;
            end
        endcase

        if (phase_reg == PH_ERR)
        begin
            restart = last_byte;
        end
        else if (err != ERR_NONE)
        begin
            // Drop the unit, then skip bytes until the last one
            res.length = '0;
            done       = 1'b0;
            if (last_byte)
            begin
                restart = 1'b1;
            end
            else
            begin
                clear_unit = 1'b1;
                phase_next = PH_ERR;
                err_next   = err;
            end
        end
        else if (last_byte)
        begin
            res.ok  = done;
            restart = 1'b1;
        end

        res.err  = err;
        res.done = done;

        if (clear_unit || restart)
        begin
            tag_acc_next  = '0;
            tag_cnt_next  = '0;
            len_acc_next  = '0;
            len_left_next = '0;
            len_kind_next = '0;
            pay_left_next = '0;
        end
        if (restart)
        begin
            phase_next = PH_TAG;
            err_next   = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG;
            tag_acc_reg  <= '0;
            tag_cnt_reg  <= '0;
            len_acc_reg  <= '0;
            len_left_reg <= '0;
            len_kind_reg <= '0;
            pay_left_reg <= '0;
            err_reg      <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tag_acc_reg  <= tag_acc_next;
            tag_cnt_reg  <= tag_cnt_next;
            len_acc_reg  <= len_acc_next;
            len_left_reg <= len_left_next;
            len_kind_reg <= len_kind_next;
            pay_left_reg <= pay_left_next;
            err_reg      <= err_next;
        end
    end
endmodule

// ===== rtl/tlvp_out_stage.sv =====
// Result register stage of the TLV unit stream parser.
module tlvp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tlvp_pkg::result_t res_in,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              ready,
    output tlvp_pkg::result_t res_out
);
    import tlvp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;
endmodule

// ===== rtl/tlv_unit_stream_parser.sv =====
// Top level of the TLV unit stream parser.
//
// Input channel: one content byte per transfer (data_byte, last_byte) under
// in_valid / in_stall. last_byte marks the end of a buffer; the parser then
// starts fresh on the next byte.
// Output channel: one result per input byte under out_valid / out_stall:
// the byte's role, payload byte, unit tag and length, parent flag, unit end,
// error code and, on the last byte, whether the whole buffer was well formed.
// A byte taken into the input register is decoded between the input register
// and the result register and shows on the outputs from the result register.
// Throughput: one byte per cycle while the receiver does not stall; the
// parse state updates as a byte moves from the input to the result register.
// Reset (rst_n low) empties both registers and returns the parser to the
// start of a tag. When the receiver stalls, the result holds, a byte is
// taken into the input register only if it is empty, and in_stall is high
// while that register holds a byte, until the result is taken.
module tlv_unit_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  byte_role,
    output logic [7:0]  payload_byte,
    output logic [28:0] unit_tag,
    output logic [63:0] unit_length,
    output logic        is_parent,
    output logic        unit_done,
    output logic [2:0]  error_code,
    output logic        content_ok
);
    import tlvp_pkg::*;

    logic       held_valid;
    logic [7:0] held_data;
    logic       held_last;
    logic       out_ready;
    logic       advance;
    result_t    res_comb;
    result_t    res_q;

    assign advance = held_valid && out_ready;

    tlvp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_data  (held_data),
        .held_last  (held_last)
    );

    tlvp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (held_data),
        .last_byte (held_last),
        .res       (res_comb)
    );

    tlvp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_comb),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .ready     (out_ready),
        .res_out   (res_q)
    );

    assign byte_role    = res_q.role;
    assign payload_byte = res_q.payload;
    assign unit_tag     = res_q.tag;
    assign unit_length  = res_q.length;
    assign is_parent    = res_q.tag[0];
    assign unit_done    = res_q.done;
    assign error_code   = res_q.err;
    assign content_ok   = res_q.ok;
endmodule

// ===== rtl/tlvp_checker.sv =====
// Port-level checks for the TLV unit stream parser, bound to the top level.
module tlvp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  byte_role,
    input logic [7:0]  payload_byte,
    input logic [28:0] unit_tag,
    input logic [63:0] unit_length,
    input logic        is_parent,
    input logic        unit_done,
    input logic [2:0]  error_code,
    input logic        content_ok
);
    import tlvp_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_role)
            && $stable(payload_byte) && $stable(unit_tag) && $stable(unit_length)
            && $stable(is_parent) && $stable(unit_done) && $stable(error_code)
            && $stable(content_ok))
        else $error("result changed while stalled");

    a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_role != ROLE_PAYLOAD |-> payload_byte == 8'd0)
        else $error("payload byte outside payload role");

    a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && content_ok |-> unit_done && error_code == ERR_NONE)
        else $error("content ok without clean unit end");

    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_role == ROLE_IGNORED |->
            error_code != ERR_NONE && !unit_done && !content_ok && unit_tag == 29'd0)
        else $error("ignored byte without latched error");

    a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_done |->
            error_code == ERR_NONE && (byte_role == ROLE_LENGTH || byte_role == ROLE_PAYLOAD))
        else $error("unit end on wrong role or with error");
endmodule

bind tlv_unit_stream_parser tlvp_checker u_tlvp_checker (.*);
